// File: design/mrrb_pkg.sv
// shared types, constants and the crc byte step for the response frame builder
// no dependencies

package mrrb_pkg;

    // request operation codes on the func input
    localparam logic [2:0] F_READ_HOLD   = 3'd0;
    localparam logic [2:0] F_READ_INP    = 3'd1;
    localparam logic [2:0] F_WRITE_ONE   = 3'd2;
    localparam logic [2:0] F_WRITE_MULTI = 3'd3;
    localparam logic [2:0] F_LOAD_HOLD   = 3'd4;
    localparam logic [2:0] F_LOAD_INP    = 3'd5;

    // function codes placed on the wire
    localparam logic [7:0] FC_READ_HOLD   = 8'h03;
    localparam logic [7:0] FC_READ_INP    = 8'h04;
    localparam logic [7:0] FC_WRITE_ONE   = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI = 8'h10;
    localparam logic [7:0] FC_EXC_FLAG    = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL_ADDRESS = 8'h02;

    // configuration register indexes
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_HOLDING_LIMIT  = 2'd1;
    localparam logic [1:0] REG_INPUT_LIMIT    = 2'd2;

    localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'd1;
    localparam logic [8:0]  LIMIT_RESET          = 9'd256;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic init;
        logic update;
    } crc_ctrl_t;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_ADDR  = 11'b000_0000_0100,
        S_CODE  = 11'b000_0000_1000,
        S_EXC   = 11'b000_0001_0000,
        S_BCNT  = 11'b000_0010_0000,
        S_DHI   = 11'b000_0100_0000,
        S_DLO   = 11'b000_1000_0000,
        S_WR    = 11'b001_0000_0000,
        S_CRCL  = 11'b010_0000_0000,
        S_CRCH  = 11'b100_0000_0000
    } state_t;

    // reflected crc-16, one byte folded in
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: design/mrrb_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module mrrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic [AW-1:0]         raddr,
    output logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/mrrb_crc.sv
// running modbus crc-16 over the frame bytes, one byte per cycle
// depends on mrrb_pkg

module mrrb_crc (
    input  logic                clk,
    input  logic                rst_n,
    input  mrrb_pkg::crc_ctrl_t ctl,
    input  logic [7:0]          data,
    output logic [15:0]         crc
);
    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.init)
            crc_next = mrrb_pkg::CRC_INIT;
        else if (ctl.update)
            crc_next = mrrb_pkg::crc_byte(crc_reg, data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= mrrb_pkg::CRC_INIT;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

// File: design/mrrb_frame.sv
// frame sequencer: request checks, store load and clear, byte-serial frame output
// depends on mrrb_pkg; drives the store rams and the crc unit

module mrrb_frame #(
    parameter int STORE_DEPTH    = 256,
    parameter int MAX_READ_COUNT = 29,
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           func,
    input  logic [15:0]          start_address,
    input  logic [15:0]          quantity,
    input  logic [15:0]          reg_value,
    input  logic [7:0]           device_address,
    input  logic [8:0]           holding_limit,
    input  logic [8:0]           input_limit,
    output logic                 hold_we,
    output logic                 inp_we,
    output logic [AW-1:0]        mem_waddr,
    output logic [15:0]          mem_wdata,
    output logic [AW-1:0]        mem_raddr,
    input  logic [15:0]          hold_rdata,
    input  logic [15:0]          inp_rdata,
    output mrrb_pkg::crc_ctrl_t  crc_ctl,
    output logic [7:0]           crc_data,
    input  logic [15:0]          crc,
    output logic [7:0]           out_byte,
    output logic                 last_byte,
    output logic                 strobe
);
    localparam int CW = $clog2(MAX_READ_COUNT + 1);
    localparam logic [AW-1:0] CLR_LAST = AW'(STORE_DEPTH - 1);

    mrrb_pkg::state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          strobe_reg, strobe_next;
    logic          last_reg, last_next;

    logic [7:0]    out_byte_reg;
    logic [7:0]    code_reg, code_next;
    logic          err_reg, err_next;
    logic          rd_inp_reg, rd_inp_next;
    logic [31:0]   pay_reg, pay_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]   addr_reg, addr_next;
    logic [1:0]    wr_idx_reg, wr_idx_next;
    logic [7:0]    lo_reg, lo_next;
    logic          oor_reg;

    logic          accept;
    logic          frame_go;
    logic          ld_ok;
    logic          clearing;
    logic [16:0]   sum;
    logic          over_cnt;
    logic [7:0]    byte_next;
    logic          emit;
    logic [15:0]   word;

    assign busy     = (state_reg != mrrb_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign frame_go = accept && ((func == mrrb_pkg::F_READ_HOLD) || (func == mrrb_pkg::F_READ_INP)
                      || (func == mrrb_pkg::F_WRITE_ONE) || (func == mrrb_pkg::F_WRITE_MULTI));
    assign clearing = (state_reg == mrrb_pkg::S_CLEAR);
    assign ld_ok    = ({1'b0, start_address} < 17'(STORE_DEPTH));

    // store writes: clearing pass after reset, or a load request
    assign hold_we   = clearing || (accept && (func == mrrb_pkg::F_LOAD_HOLD) && ld_ok);
    assign inp_we    = clearing || (accept && (func == mrrb_pkg::F_LOAD_INP) && ld_ok);
    assign mem_waddr = clearing ? clr_reg : start_address[AW-1:0];
    assign mem_wdata = clearing ? 16'h0000 : reg_value;
    assign mem_raddr = addr_reg[AW-1:0];

    // request checks
    assign sum      = {1'b0, start_address} + {1'b0, quantity};
    assign over_cnt = (quantity > 16'(MAX_READ_COUNT));

    always_comb
    begin
        err_next  = err_reg;
        code_next = code_reg;
        if (accept)
        begin
            case (func)
                mrrb_pkg::F_READ_HOLD:
                begin
                    err_next  = (sum > {8'h00, holding_limit}) || over_cnt;
                    code_next = mrrb_pkg::FC_READ_HOLD;
                end
                mrrb_pkg::F_READ_INP:
                begin
                    err_next  = (sum > {8'h00, input_limit}) || over_cnt;
                    code_next = mrrb_pkg::FC_READ_INP;
                end
                mrrb_pkg::F_WRITE_ONE:
                begin
                    err_next  = (start_address > {7'h00, holding_limit});
                    code_next = mrrb_pkg::FC_WRITE_ONE;
                end
                mrrb_pkg::F_WRITE_MULTI:
                begin
                    err_next  = (sum > {8'h00, holding_limit});
                    code_next = mrrb_pkg::FC_WRITE_MULTI;
                end
                default:
                begin
                    err_next  = 1'b0;
                    code_next = 8'h00;
                end
            endcase
        end
    end

    // read data word, zero above the store
    assign word = oor_reg ? 16'h0000 : (rd_inp_reg ? inp_rdata : hold_rdata);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        rd_inp_next = rd_inp_reg;
        pay_next    = pay_reg;
        cnt_next    = cnt_reg;
        addr_next   = addr_reg;
        wr_idx_next = wr_idx_reg;
        lo_next     = lo_reg;
        byte_next   = 8'h00;
        emit        = 1'b0;
        last_next   = 1'b0;

        case (state_reg)
            mrrb_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST)
                    state_next = mrrb_pkg::S_IDLE;
            end
            mrrb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    rd_inp_next = (func == mrrb_pkg::F_READ_INP);
                    pay_next    = {start_address,
                                   (func == mrrb_pkg::F_WRITE_ONE) ? reg_value : quantity};
                    cnt_next    = quantity[CW-1:0];
                    addr_next   = start_address;
                    wr_idx_next = 2'd0;
                end
                if (frame_go)
                    state_next = mrrb_pkg::S_ADDR;
            end
            mrrb_pkg::S_ADDR:
            begin
                emit       = 1'b1;
                byte_next  = device_address;
                state_next = mrrb_pkg::S_CODE;
            end
            mrrb_pkg::S_CODE:
            begin
                emit = 1'b1;
                if (err_reg)
                begin
                    byte_next  = code_reg | mrrb_pkg::FC_EXC_FLAG;
                    state_next = mrrb_pkg::S_EXC;
                end
                else
                begin
                    byte_next = code_reg;
                    if ((code_reg == mrrb_pkg::FC_READ_HOLD) || (code_reg == mrrb_pkg::FC_READ_INP))
                        state_next = mrrb_pkg::S_BCNT;
                    else
                        state_next = mrrb_pkg::S_WR;
                end
            end
            mrrb_pkg::S_EXC:
            begin
                emit       = 1'b1;
                byte_next  = mrrb_pkg::EXC_ILLEGAL_ADDRESS;
                state_next = mrrb_pkg::S_CRCL;
            end
            mrrb_pkg::S_BCNT:
            begin
                // ram read of the first word is in flight during this byte
                emit      = 1'b1;
                byte_next = 8'({cnt_reg, 1'b0});
                if (cnt_reg == '0)
                    state_next = mrrb_pkg::S_CRCL;
                else
                    state_next = mrrb_pkg::S_DHI;
            end
            mrrb_pkg::S_DHI:
            begin
                emit       = 1'b1;
                byte_next  = word[15:8];
                lo_next    = word[7:0];
                addr_next  = addr_reg + 16'd1;
                state_next = mrrb_pkg::S_DLO;
            end
            mrrb_pkg::S_DLO:
            begin
                emit      = 1'b1;
                byte_next = lo_reg;
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    state_next = mrrb_pkg::S_CRCL;
                else
                    state_next = mrrb_pkg::S_DHI;
            end
            mrrb_pkg::S_WR:
            begin
                // four payload bytes shifted out high first
                emit        = 1'b1;
                byte_next   = pay_reg[31:24];
                pay_next    = {pay_reg[23:0], 8'h00};
                wr_idx_next = wr_idx_reg + 2'd1;
                if (wr_idx_reg == 2'd3)
                    state_next = mrrb_pkg::S_CRCL;
            end
            mrrb_pkg::S_CRCL:
            begin
                emit       = 1'b1;
                byte_next  = crc[7:0];
                state_next = mrrb_pkg::S_CRCH;
            end
            mrrb_pkg::S_CRCH:
            begin
                emit       = 1'b1;
                byte_next  = crc[15:8];
                last_next  = 1'b1;
                state_next = mrrb_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mrrb_pkg::S_IDLE;
            end
        endcase
    end

    assign strobe_next    = emit;
    assign crc_ctl.init   = accept;
    assign crc_ctl.update = emit && (state_reg != mrrb_pkg::S_CRCL)
                            && (state_reg != mrrb_pkg::S_CRCH);
    assign crc_data       = byte_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mrrb_pkg::S_CLEAR;
            clr_reg    <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            wr_idx_reg <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
            wr_idx_reg <= wr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= byte_next;
        code_reg     <= code_next;
        err_reg      <= err_next;
        rd_inp_reg   <= rd_inp_next;
        pay_reg      <= pay_next;
        cnt_reg      <= cnt_next;
        addr_reg     <= addr_next;
        lo_reg       <= lo_next;
        oor_reg      <= ({1'b0, addr_reg} >= 17'(STORE_DEPTH));
    end

    assign out_byte  = out_byte_reg;
    assign last_byte = last_reg;
    assign strobe    = strobe_reg;

endmodule

// File: design/modbus_rtu_response_builder_top.sv
// top level of the modbus rtu response builder: configuration registers and stores
// depends on mrrb_pkg, mrrb_ram, mrrb_crc, mrrb_frame

// A request is taken when start is high and busy is low. Read and write requests
// produce the response frame on out_byte, one byte per cycle marked by strobe,
// beginning after the state register and then the output byte register are
// loaded, and ending with last_byte on the high crc byte; the receiver cannot
// stall, so every strobed byte must be taken. A frame is 5 bytes for an
// exception, 8 for a write and 5 + 2 * count for a read, up to 63; busy stays
// high while the one-byte-per-cycle sequencer steps through them, for a read
// through the single read port of the register stores. Load requests write one
// store word and leave busy low. After reset busy stays high while both stores
// are cleared; configuration writes are taken at any time but should only be
// made while busy is low and no frame bytes are pending.

module modbus_rtu_response_builder_top #(
    parameter int STORE_DEPTH    = 256,
    parameter int MAX_READ_COUNT = 29
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [15:0] start_address,
    input  logic [15:0] quantity,
    input  logic [15:0] reg_value,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    output logic [7:0]  out_byte,
    output logic        last_byte,
    output logic        strobe
);
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [7:0] device_address_reg;
    logic [8:0] holding_limit_reg;
    logic [8:0] input_limit_reg;

    logic                hold_we;
    logic                inp_we;
    logic [AW-1:0]       mem_waddr;
    logic [15:0]         mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [15:0]         hold_rdata;
    logic [15:0]         inp_rdata;
    mrrb_pkg::crc_ctrl_t crc_ctl;
    logic [7:0]          crc_data;
    logic [15:0]         crc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= mrrb_pkg::DEVICE_ADDRESS_RESET;
            holding_limit_reg  <= mrrb_pkg::LIMIT_RESET;
            input_limit_reg    <= mrrb_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mrrb_pkg::REG_DEVICE_ADDRESS: device_address_reg <= cfg_data[7:0];
                mrrb_pkg::REG_HOLDING_LIMIT:  holding_limit_reg  <= cfg_data;
                mrrb_pkg::REG_INPUT_LIMIT:    input_limit_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mrrb_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH)
    ) u_hold_ram (
        .clk   (clk),
        .we    (hold_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (hold_rdata)
    );

    mrrb_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH)
    ) u_inp_ram (
        .clk   (clk),
        .we    (inp_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (inp_rdata)
    );

    mrrb_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .data  (crc_data),
        .crc   (crc)
    );

    mrrb_frame #(
        .STORE_DEPTH    (STORE_DEPTH),
        .MAX_READ_COUNT (MAX_READ_COUNT)
    ) u_frame (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .start_address  (start_address),
        .quantity       (quantity),
        .reg_value      (reg_value),
        .device_address (device_address_reg),
        .holding_limit  (holding_limit_reg),
        .input_limit    (input_limit_reg),
        .hold_we        (hold_we),
        .inp_we         (inp_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .hold_rdata     (hold_rdata),
        .inp_rdata      (inp_rdata),
        .crc_ctl        (crc_ctl),
        .crc_data       (crc_data),
        .crc            (crc),
        .out_byte       (out_byte),
        .last_byte      (last_byte),
        .strobe         (strobe)
    );

    // the closing crc byte is always a strobed byte
    a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
        last_byte |-> strobe)
        else $error("last_byte without strobe");

    // a frame request keeps the block busy in the following cycle
    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !func[2]) |=> busy)
        else $error("frame request did not raise busy");

    // a frame's last byte is never directly followed by another strobed byte
    a_frame_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_byte) |=> !strobe)
        else $error("strobe directly after last byte");

    // load requests produce no frame bytes
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func[2] && !strobe) |=> !strobe)
        else $error("load request produced output");

endmodule

// File: sim/modbus_rtu_response_builder_top_tb.sv
// self-checking bench for modbus_rtu_response_builder_top: predicts every response frame byte
// depends on mrrb_pkg and the design sources of modbus_rtu_response_builder_top

module modbus_rtu_response_builder_top_tb;

    localparam int STORE_WORDS = 256;
    localparam int READ_MAX    = 29;
    localparam int MAX_GAP     = 17;

    // func codes the block ignores
    localparam logic [2:0] F_SPARE_6 = 3'd6;
    localparam logic [2:0] F_SPARE_7 = 3'd7;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  func = '0;
    logic [15:0] start_address = '0;
    logic [15:0] quantity = '0;
    logic [15:0] reg_value = '0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;
    logic [7:0]  out_byte;
    logic        last_byte;
    logic        strobe;

    // mirror of the block's registers and stores
    logic [7:0]  dev_addr_q;
    logic [8:0]  hold_lim_q;
    logic [8:0]  inp_lim_q;
    logic [15:0] holding_words [STORE_WORDS];
    logic [15:0] input_words [STORE_WORDS];

    frame_byte_t pending_bytes [$];
    logic [15:0] running_crc;
    int          mismatch_count = 0;
    bit          steady_feed = 1'b0;

    modbus_rtu_response_builder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .start_address (start_address),
        .quantity      (quantity),
        .reg_value     (reg_value),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_byte      (out_byte),
        .last_byte     (last_byte),
        .strobe        (strobe)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // bit-serial form of the reflected crc-16
    function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ b[i];
            r = r >> 1;
            if (fb)
                r = r ^ mrrb_pkg::CRC_POLY;
        end
        return r;
    endfunction

    function automatic void expect_byte(input logic [7:0] b);
        frame_byte_t fb;
        fb.data = b;
        fb.last = 1'b0;
        pending_bytes.push_back(fb);
        running_crc = crc_fold(running_crc, b);
    endfunction

    function automatic void expect_word(input logic [15:0] w);
        expect_byte(w[15:8]);
        expect_byte(w[7:0]);
    endfunction

    function automatic void open_frame(input logic [7:0] code);
        running_crc = mrrb_pkg::CRC_INIT;
        expect_byte(dev_addr_q);
        expect_byte(code);
    endfunction

    function automatic void close_frame();
        frame_byte_t lo;
        frame_byte_t hi;
        lo.data = running_crc[7:0];
        lo.last = 1'b0;
        hi.data = running_crc[15:8];
        hi.last = 1'b1;
        pending_bytes.push_back(lo);
        pending_bytes.push_back(hi);
    endfunction

    function automatic void expect_exception(input logic [7:0] code);
        open_frame(code | mrrb_pkg::FC_EXC_FLAG);
        expect_byte(mrrb_pkg::EXC_ILLEGAL_ADDRESS);
        close_frame();
    endfunction

    // expected frame for one request, applied to the mirrored state
    function automatic void predict_response(input logic [2:0] f, input logic [15:0] sa,
                                             input logic [15:0] cnt, input logic [15:0] val);
        logic [16:0] span;
        logic [8:0]  lim;
        logic [7:0]  code;
        int unsigned a;
        span = {1'b0, sa} + {1'b0, cnt};
        case (f)
            mrrb_pkg::F_READ_HOLD, mrrb_pkg::F_READ_INP:
            begin
                lim = (f == mrrb_pkg::F_READ_HOLD) ? hold_lim_q : inp_lim_q;
                code = (f == mrrb_pkg::F_READ_HOLD) ? mrrb_pkg::FC_READ_HOLD
                                                    : mrrb_pkg::FC_READ_INP;
                if (span > {8'h00, lim} || cnt > READ_MAX)
                    expect_exception(code);
                else
                begin
                    open_frame(code);
                    expect_byte(8'(cnt * 2));
                    for (int i = 0; i < int'(cnt); i++)
                    begin
                        a = int'(sa) + i;
                        if (a >= STORE_WORDS)
                            expect_word(16'h0000);
                        else if (f == mrrb_pkg::F_READ_HOLD)
                            expect_word(holding_words[a]);
                        else
                            expect_word(input_words[a]);
                    end
                    close_frame();
                end
            end
            mrrb_pkg::F_WRITE_ONE:
            begin
                if ({1'b0, sa} > {8'h00, hold_lim_q})
                    expect_exception(mrrb_pkg::FC_WRITE_ONE);
                else
                begin
                    open_frame(mrrb_pkg::FC_WRITE_ONE);
                    expect_word(sa);
                    expect_word(val);
                    close_frame();
                end
            end
            mrrb_pkg::F_WRITE_MULTI:
            begin
                if (span > {8'h00, hold_lim_q})
                    expect_exception(mrrb_pkg::FC_WRITE_MULTI);
                else
                begin
                    open_frame(mrrb_pkg::FC_WRITE_MULTI);
                    expect_word(sa);
                    expect_word(cnt);
                    close_frame();
                end
            end
            mrrb_pkg::F_LOAD_HOLD:
                if (sa < STORE_WORDS)
                    holding_words[sa] = val;
            mrrb_pkg::F_LOAD_INP:
                if (sa < STORE_WORDS)
                    input_words[sa] = val;
            default:
                ;
        endcase
    endfunction

    // one request transfer; returns at the accepting edge with start still high
    task automatic send_request(input logic [2:0] f, input logic [15:0] sa,
                                input logic [15:0] cnt, input logic [15:0] val);
        int gap;
        gap = steady_feed ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        func <= f;
        start_address <= sa;
        quantity <= cnt;
        reg_value <= val;
        do
            @(posedge clk);
        while (busy);
        predict_response(f, sa, cnt, val);
    endtask

    // stop sending and let every expected byte arrive
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_bytes.size() != 0 || busy);
        // a trailing load may still be writing its store word
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input logic [7:0] dev, input logic [8:0] hl,
                                input logic [8:0] il);
        cfg_we <= 1'b1;
        cfg_index <= mrrb_pkg::REG_DEVICE_ADDRESS;
        cfg_data <= {1'b0, dev};
        @(posedge clk);
        dev_addr_q = dev;
        cfg_index <= mrrb_pkg::REG_HOLDING_LIMIT;
        cfg_data <= hl;
        @(posedge clk);
        hold_lim_q = hl;
        cfg_index <= mrrb_pkg::REG_INPUT_LIMIT;
        cfg_data <= il;
        @(posedge clk);
        inp_lim_q = il;
        cfg_we <= 1'b0;
    endtask

    // each strobed byte is taken at the edge that ends its cycle
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && strobe === 1'b1)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, last_byte));
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte, want.data));
                if (last_byte !== want.last)
                    report_mismatch($sformatf("last_byte %0b, expected %0b",
                                              last_byte, want.last));
            end
        end
    end

    task automatic test_reset_state();
        send_request(mrrb_pkg::F_READ_HOLD, 16'd0, 16'd0, 16'hFFFF);
        send_request(mrrb_pkg::F_READ_INP, 16'd0, 16'd2, 16'h0000);
        send_request(F_SPARE_6, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_store_access();
        send_request(mrrb_pkg::F_LOAD_HOLD, 16'd0, 16'd0, 16'hFFFF);
        send_request(mrrb_pkg::F_LOAD_HOLD, 16'd255, 16'hFFFF, 16'hA5A5);
        send_request(mrrb_pkg::F_LOAD_HOLD, 16'd256, 16'd0, 16'h1234);
        send_request(mrrb_pkg::F_LOAD_INP, 16'hFFFF, 16'd0, 16'hFFFF);
        send_request(mrrb_pkg::F_LOAD_INP, 16'd0, 16'd0, 16'h5A5A);
        send_request(mrrb_pkg::F_READ_HOLD, 16'd253, 16'd3, 16'd0);
        send_request(mrrb_pkg::F_READ_INP, 16'd0, 16'd29, 16'd0);
        send_request(mrrb_pkg::F_READ_HOLD, 16'd0, 16'd30, 16'd0);
        send_request(F_SPARE_7, 16'd0, 16'd1, 16'd0);
    endtask

    task automatic test_write_responses();
        send_request(mrrb_pkg::F_WRITE_ONE, 16'd256, 16'd0, 16'hFFFF);
        send_request(mrrb_pkg::F_WRITE_ONE, 16'd257, 16'd0, 16'h0000);
        send_request(mrrb_pkg::F_WRITE_MULTI, 16'd0, 16'd256, 16'd0);
        send_request(mrrb_pkg::F_WRITE_MULTI, 16'd255, 16'hFFFF, 16'd0);
        send_request(mrrb_pkg::F_READ_INP, 16'd1, 16'd256, 16'd0);
    endtask

    task automatic test_limit_extremes();
        wait_drained();
        apply_config(8'd247, 9'd0, 9'd0);
        send_request(mrrb_pkg::F_READ_HOLD, 16'd0, 16'd0, 16'd0);
        send_request(mrrb_pkg::F_READ_INP, 16'd0, 16'd1, 16'd0);
        send_request(mrrb_pkg::F_WRITE_ONE, 16'd0, 16'd0, 16'h8001);
        send_request(mrrb_pkg::F_WRITE_MULTI, 16'd0, 16'd1, 16'd0);
        wait_drained();
        // limits past the store: the tail of a read comes back as zero
        apply_config(8'd1, 9'd511, 9'd511);
        send_request(mrrb_pkg::F_READ_HOLD, 16'd250, 16'd20, 16'd0);
        send_request(mrrb_pkg::F_READ_INP, 16'hFFFF, 16'hFFFF, 16'd0);
        send_request(mrrb_pkg::F_WRITE_ONE, 16'd511, 16'd0, 16'h7FFE);
        send_request(mrrb_pkg::F_WRITE_ONE, 16'hFFFF, 16'd0, 16'd0);
    endtask

    function automatic logic [8:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return 9'd0;
            1: return 9'd256;
            2: return 9'd511;
            default: return 9'($urandom_range(0, 256));
        endcase
    endfunction

    task automatic send_random_request(output bit counted);
        int unsigned pick;
        logic [2:0]  f;
        logic [15:0] sa;
        logic [15:0] cnt;
        logic [15:0] val;
        pick = $urandom_range(0, 99);
        val = 16'($urandom);
        cnt = 16'($urandom);
        if (pick < 35)
        begin
            f = $urandom_range(0, 1) ? mrrb_pkg::F_LOAD_HOLD : mrrb_pkg::F_LOAD_INP;
            sa = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(0, 255)) : 16'($urandom);
        end
        else if (pick < 70)
        begin
            f = $urandom_range(0, 1) ? mrrb_pkg::F_READ_HOLD : mrrb_pkg::F_READ_INP;
            sa = ($urandom_range(0, 6) != 0) ? 16'($urandom_range(0, 300)) : 16'($urandom);
            if ($urandom_range(0, 9) != 0)
                cnt = 16'($urandom_range(0, READ_MAX));
        end
        else if (pick < 82)
        begin
            f = mrrb_pkg::F_WRITE_ONE;
            sa = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 511)) : 16'($urandom);
        end
        else if (pick < 94)
        begin
            f = mrrb_pkg::F_WRITE_MULTI;
            sa = 16'($urandom_range(0, 300));
            if ($urandom_range(0, 4) != 0)
                cnt = 16'($urandom_range(0, 300));
        end
        else
        begin
            f = 3'($urandom_range(0, 7));
            sa = 16'($urandom);
        end
        counted = !(f == F_SPARE_6 || f == F_SPARE_7 ||
                    ((f == mrrb_pkg::F_LOAD_HOLD || f == mrrb_pkg::F_LOAD_INP)
                     && sa >= STORE_WORDS));
        send_request(f, sa, cnt, val);
    endtask

    task automatic test_random_traffic();
        int n;
        bit counted;
        for (int phase = 0; phase < 5; phase++)
        begin
            wait_drained();
            apply_config(8'($urandom_range(1, 247)), pick_limit(), pick_limit());
            steady_feed = (phase == 2);
            n = 0;
            while (n < 35)
            begin
                if ($urandom_range(0, 24) == 0)
                    wait_drained();
                send_random_request(counted);
                if (counted)
                    n++;
            end
        end
        steady_feed = 1'b0;
    endtask

    initial
    begin
        dev_addr_q = mrrb_pkg::DEVICE_ADDRESS_RESET;
        hold_lim_q = mrrb_pkg::LIMIT_RESET;
        inp_lim_q = mrrb_pkg::LIMIT_RESET;
        for (int i = 0; i < STORE_WORDS; i++)
        begin
            holding_words[i] = '0;
            input_words[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_store_access();
        test_write_responses();
        test_limit_extremes();
        test_random_traffic();
        wait_drained();
        if (mismatch_count == 0)
            $display("modbus_rtu_response_builder_top test passed");
        else
            $display("modbus_rtu_response_builder_top test failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("modbus_rtu_response_builder_top test failed");
        $finish;
    end

endmodule
